@@ rtl/core/bsc_pkg.sv @@
package bsc_pkg;

  // Data that rides alongside the divider pipeline
  typedef struct packed {
    logic signed [14:0] temp;   // compensated temperature, already saturated
    logic               ok;     // divisor non-zero
    logic               neg;    // quotient sign
  } side_t;

  typedef struct packed {
    logic [63:0] num;           // numerator magnitude
    logic [30:0] den;           // divisor magnitude
    side_t       side;
  } div_req_t;

  typedef struct packed {
    logic [63:0] quo;           // quotient magnitude
    side_t       side;
  } div_rsp_t;

endpackage

@@ rtl/core/bsc_div.sv @@
// Unsigned restoring divider, one quotient bit per stage.
// The numerator register shifts left each stage; quotient bits fill from the bottom.
module bsc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  bsc_pkg::div_req_t req,
  output logic              out_vld,
  output bsc_pkg::div_rsp_t rsp
);

  localparam int STAGES = 64;

  logic                  vld_q  [STAGES];
  logic [63:0]           num_q  [STAGES];
  logic [30:0]           rem_q  [STAGES];
  logic [30:0]           den_q  [STAGES];
  bsc_pkg::side_t        side_q [STAGES];

  logic                  src_vld  [STAGES];
  logic [63:0]           src_num  [STAGES];
  logic [30:0]           src_rem  [STAGES];
  logic [30:0]           src_den  [STAGES];
  bsc_pkg::side_t        src_side [STAGES];
  logic [31:0]           trial    [STAGES];
  logic                  ge       [STAGES];

  always_comb begin
    src_vld[0]  = in_vld;
    src_num[0]  = req.num;
    src_rem[0]  = '0;
    src_den[0]  = req.den;
    src_side[0] = req.side;
    for (int k = 1; k < STAGES; k++) begin
      src_vld[k]  = vld_q[k-1];
      src_num[k]  = num_q[k-1];
      src_rem[k]  = rem_q[k-1];
      src_den[k]  = den_q[k-1];
      src_side[k] = side_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      trial[k] = {src_rem[k], src_num[k][63]};
      ge[k]    = trial[k] >= {1'b0, src_den[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= src_vld[k];
      end
      if (en) begin
        num_q[k]  <= {src_num[k][62:0], ge[k]};
        rem_q[k]  <= ge[k] ? 31'(trial[k] - {1'b0, src_den[k]}) : trial[k][30:0];
        den_q[k]  <= src_den[k];
        side_q[k] <= src_side[k];
      end
    end
  end

  assign out_vld   = vld_q[STAGES-1];
  assign rsp.quo   = num_q[STAGES-1];
  assign rsp.side  = side_q[STAGES-1];

  // final partial remainder below the divisor whenever the divisor is non-zero
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld_q[STAGES-1] && den_q[STAGES-1] != '0 |-> rem_q[STAGES-1] < den_q[STAGES-1])
    else $error("divider remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(num_q[STAGES-1]) && $stable(vld_q[STAGES-1]))
    else $error("divider moved while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_vld)
    else $error("divider output valid after reset");

endmodule

@@ rtl/core/barometric_sensor_compensation.sv @@
// Barometric temperature and pressure compensation, integer datasheet form.
// Each request on the slave stream carries one raw temperature and one raw
// pressure conversion; one result leaves on the master stream per request, in
// order. The pipeline takes a request every cycle while the output is not
// stalled: 11 stages work out the fine temperature, the saturated temperature
// and the pressure divisor and numerator, a 64-stage divider (one quotient
// bit per stage) forms the quotient, 7 further stages apply the second-order
// correction, and the output register saturates the pressure. A stall at the
// output freezes the whole pipeline. Calibration words are written on the cfg
// channel, which is always ready; write them only while no request is in
// flight. A zero divisor gives pressure 0 with the pressure valid flag (tuser)
// low.
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // temperature_centi[14:0], pressure_q17_8[39:15]
  output logic        m_axis_tuser,   // pressure_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // register map
  localparam logic [1:0] REG_CALIB_TEMP  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [1:0] REG_PRESS_LAST  = 2'd3;

  localparam logic signed [19:0] TEMP_MIN    = -20'sd4000;
  localparam logic signed [19:0] TEMP_MAX    = 20'sd8500;
  localparam logic [11:0]        PRESS_SCALE = 12'd3125;
  localparam logic [24:0]        PRESS_MAX   = '1;

  // ---------------------------------------------------------------- config
  logic [47:0] calib_temp;
  logic [63:0] calib_press_low;
  logic [63:0] calib_press_high;
  logic [15:0] calib_press_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_temp       <= '0;
      calib_press_low  <= '0;
      calib_press_high <= '0;
      calib_press_last <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CALIB_TEMP: calib_temp       <= cfg_data[47:0];
        REG_PRESS_LOW:  calib_press_low  <= cfg_data;
        REG_PRESS_HIGH: calib_press_high <= cfg_data;
        REG_PRESS_LAST: calib_press_last <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // calibration words
  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = calib_temp[15:0];
  assign t2 = $signed(calib_temp[31:16]);
  assign t3 = $signed(calib_temp[47:32]);
  assign p1 = calib_press_low[15:0];
  assign p2 = $signed(calib_press_low[31:16]);
  assign p3 = $signed(calib_press_low[47:32]);
  assign p4 = $signed(calib_press_low[63:48]);
  assign p5 = $signed(calib_press_high[15:0]);
  assign p6 = $signed(calib_press_high[31:16]);
  assign p7 = $signed(calib_press_high[47:32]);
  assign p8 = $signed(calib_press_high[63:48]);
  assign p9 = $signed(calib_press_last);

  // ---------------------------------------------------------------- flow
  // whole pipeline advances together whenever the output slot is free
  logic        en;
  logic [11:1] pv;
  logic [7:1]  qv;
  logic        div_vld;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv            <= '0;
      qv            <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      pv            <= {pv[10:1], s_axis_tvalid};
      qv            <= {qv[6:1], div_vld};
      m_axis_tvalid <= qv[7];
    end
  end

  // ---------------------------------------------------------------- temperature
  logic signed [17:0] s1_a;
  logic signed [16:0] s1_b;
  logic        [19:0] s1_rawp, s2_rawp, s3_rawp, s4_rawp, s5_rawp, s6_rawp, s7_rawp;
  logic signed [33:0] s2_pa, s2_bb;
  logic signed [22:0] s3_v1t;
  logic signed [37:0] s3_m3;
  logic signed [23:0] s4_fine;
  logic signed [14:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic signed [47:0] s5_sq;
  logic signed [39:0] s5_m5, s5_m2;

  logic signed [23:0] v1c;
  logic signed [27:0] tf;
  logic signed [19:0] tt;

  always_comb begin
    v1c = 24'(s4_fine - 24'sd128000);
    tf  = 28'(s4_fine * 28'sd5 + 28'sd128);
    tt  = $signed(tf[27:8]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offsets against T1
      s1_a    <= 18'({1'b0, s_axis_tdata[19:3]} - {1'b0, t1, 1'b0});
      s1_b    <= 17'({1'b0, s_axis_tdata[19:4]} - {1'b0, t1});
      s1_rawp <= s_axis_tdata[39:20];
      // stage 2
      s2_pa   <= s1_a * t2;
      s2_bb   <= s1_b * s1_b;
      s2_rawp <= s1_rawp;
      // stage 3
      s3_v1t  <= $signed(s2_pa[33:11]);
      s3_m3   <= $signed(s2_bb[33:12]) * t3;
      s3_rawp <= s2_rawp;
      // stage 4: fine temperature
      s4_fine <= 24'(s3_v1t + $signed(s3_m3[37:14]));
      s4_rawp <= s3_rawp;
      // stage 5: centidegrees, pressure first-order products
      if (tt < TEMP_MIN) begin
        s5_temp <= 15'(TEMP_MIN);
      end else if (tt > TEMP_MAX) begin
        s5_temp <= 15'(TEMP_MAX);
      end else begin
        s5_temp <= 15'(tt);
      end
      s5_sq   <= v1c * v1c;
      s5_m5   <= v1c * p5;
      s5_m2   <= v1c * p2;
      s5_rawp <= s4_rawp;
    end
  end

  // ---------------------------------------------------------------- pressure terms
  logic signed [40:0] s6_lo6, s6_hi6, s6_lo3, s6_hi3;
  logic signed [63:0] s6_v2p, s6_m2s;
  logic signed [63:0] s7_v2, s7_v1p;
  logic        [63:0] s8_w, s8_num;
  logic        [47:0] s9_wl;
  logic        [31:0] s9_wh, s9_nh;
  logic        [43:0] s9_nl;
  logic signed [30:0] s10_den;
  logic        [63:0] s10_num;
  bsc_pkg::div_req_t  s11_req;

  logic signed [63:0] x6, x3;
  logic        [20:0] pdiff;
  logic        [63:0] prod1, numer;

  always_comb begin
    x6    = (64'(s6_hi6) <<< 24) + 64'(s6_lo6);
    x3    = (64'(s6_hi3) <<< 24) + 64'(s6_lo3);
    pdiff = 21'(21'h100000 - {1'b0, s7_rawp});
    prod1 = {16'b0, s9_wl} + {s9_wh, 32'b0};
    numer = {20'b0, s9_nl} + {s9_nh, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 6: square times P6 / P3 in two halves
      s6_lo6  <= $signed({1'b0, s5_sq[23:0]}) * p6;
      s6_hi6  <= $signed({1'b0, s5_sq[47:24]}) * p6;
      s6_lo3  <= $signed({1'b0, s5_sq[23:0]}) * p3;
      s6_hi3  <= $signed({1'b0, s5_sq[47:24]}) * p3;
      s6_v2p  <= (64'(s5_m5) <<< 17) + (64'(p4) <<< 35);
      s6_m2s  <= 64'(s5_m2) <<< 12;
      s6_temp <= s5_temp;
      s6_rawp <= s5_rawp;
      // stage 7
      s7_v2   <= x6 + s6_v2p;
      s7_v1p  <= (x3 >>> 8) + s6_m2s;
      s7_temp <= s6_temp;
      s7_rawp <= s6_rawp;
      // stage 8
      s8_w    <= 64'(s7_v1p) + 64'h0000_8000_0000_0000;
      s8_num  <= ({43'b0, pdiff} << 31) - 64'(s7_v2);
      s8_temp <= s7_temp;
      // stage 9: 64 x 16 and 64 x 12 products, low 64 bits, as two halves
      s9_wl   <= s8_w[31:0] * p1;
      s9_wh   <= 32'(s8_w[63:32] * p1);
      s9_nl   <= s8_num[31:0] * PRESS_SCALE;
      s9_nh   <= 32'(s8_num[63:32] * PRESS_SCALE);
      s9_temp <= s8_temp;
      // stage 10: divisor and numerator
      s10_den  <= $signed(prod1[63:33]);
      s10_num  <= numer;
      s10_temp <= s9_temp;
      // stage 11: sign and magnitude for the divider
      s11_req.num       <= s10_num[63] ? 64'(~s10_num + 64'd1) : s10_num;
      s11_req.den       <= s10_den[30] ? 31'(-s10_den) : 31'(s10_den);
      s11_req.side.neg  <= s10_num[63] ^ s10_den[30];
      s11_req.side.ok   <= s10_den != '0;
      s11_req.side.temp <= s10_temp;
    end
  end

  // ---------------------------------------------------------------- divider
  bsc_pkg::div_rsp_t div_rsp;

  bsc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (pv[11]),
    .req     (s11_req),
    .out_vld (div_vld),
    .rsp     (div_rsp)
  );

  // ---------------------------------------------------------------- second-order correction
  logic        [63:0] q1_p, q2_p, q3_p, q4_p, q5_p;
  logic        [63:0] q2_a, q3_a, q3_c, q3_e;
  logic signed [48:0] q2_cl, q2_el;
  logic        [31:0] q2_ch, q2_eh;
  logic        [63:0] q4_ll;
  logic        [31:0] q4_lh, q4_hl;
  logic signed [63:0] q4_v2e, q5_v2e;
  logic        [63:0] q5_b;
  logic signed [63:0] q6_s, q7_r;
  bsc_pkg::side_t     q1_side, q2_side, q3_side, q4_side, q5_side, q6_side, q7_side;

  logic signed [63:0] a13;

  assign a13 = $signed(q1_p) >>> 13;

  always_ff @(posedge clk) begin
    if (en) begin
      // q1: signed quotient
      q1_p    <= div_rsp.side.neg ? 64'(~div_rsp.quo + 64'd1) : div_rsp.quo;
      q1_side <= div_rsp.side;
      // q2: P9 * a and P8 * p in halves
      q2_cl   <= $signed({1'b0, a13[31:0]}) * p9;
      q2_ch   <= 32'($signed(a13[63:32]) * p9);
      q2_el   <= $signed({1'b0, q1_p[31:0]}) * p8;
      q2_eh   <= 32'($signed(q1_p[63:32]) * p8);
      q2_a    <= a13;
      q2_p    <= q1_p;
      q2_side <= q1_side;
      // q3
      q3_c    <= 64'(q2_cl) + {q2_ch, 32'b0};
      q3_e    <= 64'(q2_el) + {q2_eh, 32'b0};
      q3_a    <= q2_a;
      q3_p    <= q2_p;
      q3_side <= q2_side;
      // q4: (P9 * a) * a, low 64 bits
      q4_ll   <= q3_c[31:0] * q3_a[31:0];
      q4_lh   <= 32'(q3_c[31:0] * q3_a[63:32]);
      q4_hl   <= 32'(q3_c[63:32] * q3_a[31:0]);
      q4_v2e  <= $signed(q3_e) >>> 19;
      q4_p    <= q3_p;
      q4_side <= q3_side;
      // q5
      q5_b    <= q4_ll + {32'(q4_lh + q4_hl), 32'b0};
      q5_v2e  <= q4_v2e;
      q5_p    <= q4_p;
      q5_side <= q4_side;
      // q6
      q6_s    <= $signed(q5_p) + ($signed(q5_b) >>> 25) + q5_v2e;
      q6_side <= q5_side;
      // q7: back to Pa Q24.8 plus P7 offset
      q7_r    <= (q6_s >>> 8) + (64'(p7) <<< 4);
      q7_side <= q6_side;
      // output register
      m_axis_tdata[14:0] <= q7_side.temp;
      m_axis_tuser       <= q7_side.ok;
      if (!q7_side.ok || q7_r[63]) begin
        m_axis_tdata[39:15] <= '0;
      end else if (|q7_r[62:25]) begin
        m_axis_tdata[39:15] <= PRESS_MAX;
      end else begin
        m_axis_tdata[39:15] <= q7_r[24:0];
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:15] == '0)
    else $error("pressure non-zero with zero divisor");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[14:0]) >= -15'sd4000
                   && $signed(m_axis_tdata[14:0]) <= 15'sd8500)
    else $error("temperature outside saturation range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pv) && $stable(qv))
    else $error("pipeline valids moved during stall");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid straight after reset");

endmodule
